// File: src/fts_pkg.sv
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types, widths and helpers for the Fenwick tree sum store.
// ----------------------------------------------------------------------------
package fts_pkg;

  // Tree geometry
  localparam int ENTRIES = 1024;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int IDX_W   = ADDR_W + 1;

  // Field widths
  localparam int ACT_W   = 2;
  localparam int DELTA_W = 32;
  localparam int SUM_W   = 48;
  localparam int SIZE_W  = 11;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = ((IDX_W + DELTA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SUM_W + 7) / 8) * 8;

  // Action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_PREFIX = 2'd1,
    ACT_POINT  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_QUERY,
    S_DONE
  } state_t;

  // Lowest set bit of a node number
  function automatic logic [IDX_W:0] low_bit(input logic [IDX_W:0] v);
    return v & (~v + 1'b1);
  endfunction

endpackage

// File: src/fenwick_tree_sum_store_top.sv
// Walk: an add reads and writes each node on its path, a query reads each node on
//   its path (up to 11 nodes either way); a prefix query at index 0, flagged
//   items, no-ops and point queries at index 0 read no node.
// Items are handled one at a time; the next is accepted in the cycle after a result loads.
// Reset: synchronous; afterwards a clearing pass writes zero to all 1024 nodes,
//   during which no input is accepted. size_in_use resets to 1024.
// ----------------------------------------------------------------------------
// fenwick_tree_sum_store_top
// Binary indexed tree over a single-port-pair node RAM: add, prefix, point.
// ----------------------------------------------------------------------------
module fenwick_tree_sum_store_top (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: size_in_use
  input  logic                            cfg_we,
  input  logic [fts_pkg::SIZE_W-1:0]      cfg_wdata,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fts_pkg::IN_DATA_W-1:0]   s_tdata,   // index[10:0], delta[42:11], zero pad
  input  logic [fts_pkg::ACT_W-1:0]       s_tuser,   // action[1:0]
  // Output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fts_pkg::OUT_DATA_W-1:0]  m_tdata,   // sum[47:0]
  output logic                            m_tuser    // out_of_range[0]
);

  import fts_pkg::*;

  state_t state, state_next;

  logic [SIZE_W-1:0]  size_in_use;
  logic [IDX_W-1:0]   lim;
  logic [ADDR_W-1:0]  clr_cnt;

  // Item registers
  action_t            act;
  logic [IDX_W-1:0]   cur;
  logic [IDX_W-1:0]   stop;
  logic               first;
  logic               pend;
  logic               pend_neg;
  logic [SUM_W-1:0]   delta_ext;
  logic [SUM_W-1:0]   acc;
  logic               flag;

  // Input unpacking
  logic [IDX_W-1:0]   in_index;
  logic [DELTA_W-1:0] in_delta;
  action_t            in_act;
  logic               in_xfer;
  logic               bad_add;
  logic               bad_qry;

  // Walk arithmetic
  logic [IDX_W:0]     cur_ext;
  logic [IDX_W:0]     cur_lb;
  logic [IDX_W:0]     up_next;
  logic [IDX_W:0]     down_next;
  logic               up_go;
  logic               q_go;
  logic [IDX_W-1:0]   in_lb;

  // RAM ports
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [SUM_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [SUM_W-1:0]   ram_rdata;

  logic               out_load;

  assign in_index = s_tdata[IDX_W-1:0];
  assign in_delta = s_tdata[IDX_W +: DELTA_W];
  assign in_act   = action_t'(s_tuser);
  assign in_xfer  = s_tvalid && s_tready;
  assign in_lb    = IDX_W'(low_bit({1'b0, in_index}));

  // Active limit, saturated to the tree size
  assign lim = (size_in_use > SIZE_W'(ENTRIES)) ? IDX_W'(ENTRIES) : IDX_W'(size_in_use);

  assign bad_add = (in_index == '0) || (in_index > lim);
  assign bad_qry = (in_index > lim);

  assign cur_ext   = {1'b0, cur};
  assign cur_lb    = low_bit(cur_ext);
  assign up_next   = cur_ext + cur_lb;
  assign down_next = cur_ext - cur_lb;
  assign up_go     = (up_next <= {1'b0, lim});
  assign q_go      = first || (cur > stop);

  assign out_load  = (state == S_DONE) && (!m_tvalid || m_tready);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_W'(ENTRIES);
    end else if (cfg_we) begin
      size_in_use <= cfg_wdata;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == ADDR_W'(ENTRIES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          case (in_act)
            ACT_ADD:    state_next = bad_add ? S_DONE : S_ADD_RD;
            ACT_PREFIX: state_next = bad_qry ? S_DONE : S_QUERY;
            ACT_POINT:  state_next = (bad_qry || in_index == '0) ? S_DONE : S_QUERY;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_ADD_RD: state_next = S_ADD_WR;
      S_ADD_WR: begin
        if (!up_go) state_next = S_DONE;
      end
      S_QUERY: begin
        if (!q_go && !pend) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: input ready and node RAM control
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(cur - 1'b1);
    ram_wdata = ram_rdata + delta_ext;
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(cur - 1'b1);
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      S_IDLE:   s_tready = 1'b1;
      S_ADD_RD: ram_re = 1'b1;
      S_ADD_WR: begin
        // write this node, fetch its parent in the same cycle
        ram_we    = 1'b1;
        ram_re    = up_go;
        ram_raddr = ADDR_W'(up_next - 1'b1);
      end
      S_QUERY:  ram_re = q_go;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == S_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Walk control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      first    <= 1'b0;
      pend     <= 1'b0;
      pend_neg <= 1'b0;
    end else if (state == S_IDLE && in_xfer) begin
      first    <= (in_act == ACT_POINT);
      pend     <= 1'b0;
      pend_neg <= 1'b0;
    end else if (state == S_QUERY) begin
      pend <= q_go;
      if (first) begin
        first    <= 1'b0;
        pend_neg <= 1'b0;
      end else begin
        pend_neg <= (act == ACT_POINT);
      end
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          act       <= in_act;
          cur       <= in_index;
          delta_ext <= {{(SUM_W - DELTA_W){in_delta[DELTA_W-1]}}, in_delta};
          acc       <= '0;
          stop      <= (in_act == ACT_POINT) ? (in_index - in_lb) : '0;
          case (in_act)
            ACT_ADD:    flag <= bad_add;
            ACT_PREFIX: flag <= bad_qry;
            ACT_POINT:  flag <= bad_qry;
            default:    flag <= 1'b0;
          endcase
        end
      end
      S_ADD_WR: begin
        cur <= IDX_W'(up_next);
      end
      S_QUERY: begin
        // fold in the node read last cycle
        if (pend) begin
          acc <= pend_neg ? (acc - ram_rdata) : (acc + ram_rdata);
        end
        if (first) begin
          cur <= cur - 1'b1;
        end else if (q_go) begin
          cur <= IDX_W'(down_next);
        end
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_DATA_W'(acc);
      m_tuser <= flag;
    end
  end

  // Node store
  fts_ram #(
    .WIDTH (SUM_W),
    .DEPTH (ENTRIES)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: src/fts_ram.sv
// ----------------------------------------------------------------------------
// fts_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/fts_checker.sv
// ----------------------------------------------------------------------------
// fts_checker
// Port-level checks for the Fenwick tree sum store, bound to the top level.
// ----------------------------------------------------------------------------
module fts_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [fts_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic                            m_tuser
);

  // No result is pending right after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Clearing pass holds off input after reset
  a_rst_in: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready during clearing pass");

  // One item at a time: an input transfer drops ready
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in flight");

  // A flagged result carries a zero sum
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("out-of-range result with nonzero sum");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind fenwick_tree_sum_store_top fts_checker u_fts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: tb/fenwick_tree_sum_store_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fenwick_tree_sum_store_top_tb
// Self-checking bench for the Fenwick tree sum store. A table of directed
// transfers (empty tree, index 0, out-of-range index, unused action, extreme
// deltas) runs first. Random add/prefix/point traffic follows under several
// size_in_use settings, including 0, 1, 1024, 2047 and a shrink after adds.
// Every result is compared against a behavioral tree kept in the bench.
// ----------------------------------------------------------------------------
module fenwick_tree_sum_store_top_tb;
  import fts_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 5;
  // Clearing pass plus the long receiver hold-off fit well inside
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 16;
  localparam int PHASES         = 8;
  localparam int DIRECTED_ROWS  = 23;

  // Expected result of one transfer
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             oor;
  } result_t;

  // One directed transfer; known marks a result typed in by hand
  typedef struct {
    action_t            act;
    logic [IDX_W-1:0]   idx;
    logic [DELTA_W-1:0] delta;
    bit                 known;
    result_t            res;
  } stim_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [SIZE_W-1:0]     cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;   // index[10:0], delta[42:11], zero pad
  logic [ACT_W-1:0]      s_tuser   = '0;   // action[1:0]
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;          // sum[47:0]
  logic                  m_tuser;          // out_of_range[0]

  // Bench copy of the tree and of the size register
  logic [SUM_W-1:0]  tree_nodes [1:ENTRIES];
  logic [SIZE_W-1:0] size_model = 11'd1024;
  result_t           pending_sums [$];

  int mismatch_count = 0;
  int send_idle_pct  = 35;
  int recv_idle_pct  = 86;
  int hold_seq       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  stim_row_t directed_rows [DIRECTED_ROWS];
  int        phase_size  [PHASES] = '{1024, 2047, 1, 0, 0, 16, 1024, 300};
  int        phase_items [PHASES] = '{100, 80, 40, 25, 120, 80, 120, 60};

  fenwick_tree_sum_store_top DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    foreach (tree_nodes[n]) tree_nodes[n] = '0;
  end

  // Apply one action to the bench tree and return its result
  function automatic result_t tree_apply(action_t act, int idx, logic [DELTA_W-1:0] delta);
    int               lim;
    int               node;
    int               stop;
    logic [SUM_W-1:0] acc;
    result_t          res;
    lim     = (size_model > ENTRIES) ? ENTRIES : int'(size_model);
    acc     = '0;
    res.oor = 1'b0;
    case (act)
      ACT_ADD: begin
        if (idx == 0 || idx > lim) begin
          res.oor = 1'b1;
        end else begin
          // walk up through parents while inside the active size
          node = idx;
          while (node <= lim) begin
            tree_nodes[node] += {{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta};
            node += node & -node;
          end
        end
      end
      ACT_PREFIX: begin
        if (idx > lim) begin
          res.oor = 1'b1;
        end else begin
          node = idx;
          while (node > 0) begin
            acc += tree_nodes[node];
            node -= node & -node;
          end
        end
      end
      ACT_POINT: begin
        if (idx > lim) begin
          res.oor = 1'b1;
        end else if (idx != 0) begin
          // own node minus the nodes covering its lower children
          stop = idx - (idx & -idx);
          acc  = tree_nodes[idx];
          node = idx - 1;
          while (node > stop) begin
            acc -= tree_nodes[node];
            node -= node & -node;
          end
        end
      end
      default: ;
    endcase
    res.sum = acc;
    return res;
  endfunction

  // Append one expected result to the scoreboard queue
  function automatic void queue_result(result_t res);
    pending_sums = {pending_sums, res};
  endfunction

  // Offer one item after a random gap; record its expected result on transfer
  task automatic send_item(action_t act, logic [IDX_W-1:0] idx, logic [DELTA_W-1:0] delta,
                           bit known = 1'b0, result_t given = '0);
    int      gap = 0;
    result_t res;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {{(IN_DATA_W-DELTA_W-IDX_W){1'b0}}, delta, idx};
    do @(posedge clk); while (!s_tready);
    res = tree_apply(act, int'(idx), delta);
    queue_result(known ? given : res);
  endtask

  // Random item, mostly in range, with some index 0 and out-of-range noise
  task automatic send_random_item();
    int                 lim;
    int                 pick;
    action_t            act;
    logic [IDX_W-1:0]   idx;
    logic [DELTA_W-1:0] delta;
    lim  = (size_model > ENTRIES) ? ENTRIES : int'(size_model);
    pick = $urandom_range(99);
    act  = (pick < 45) ? ACT_ADD : (pick < 70) ? ACT_PREFIX :
           (pick < 94) ? ACT_POINT : ACT_NOP;
    pick = $urandom_range(99);
    if (pick < 8 || lim == 0)  idx = IDX_W'($urandom_range(2047));
    else if (pick < 12)        idx = '0;
    else if (pick < 18)        idx = IDX_W'(lim);
    else if (pick < 22)        idx = IDX_W'(lim + 1);
    else                       idx = IDX_W'($urandom_range(lim, 1));
    pick = $urandom_range(99);
    if (pick < 50)       delta = $urandom();
    else if (pick < 85)  delta = $urandom_range(200) - 100;
    else if (pick < 93)  delta = 32'h7FFF_FFFF;
    else                 delta = 32'h8000_0000;
    send_item(act, idx, delta);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_sums.size() != 0);
  endtask

  // Write size_in_use while the block is idle
  task automatic write_size(logic [SIZE_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    size_model  = value;
  endtask

  // Result checking and receiver ready generation
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result transfer: sum %0h, out_of_range %0b",
               m_tdata[SUM_W-1:0], m_tuser);
        mismatch_count++;
      end else begin
        want = pending_sums.pop_front();
        if (m_tdata[SUM_W-1:0] !== want.sum) begin
          $error("sum: expected %0h, actual %0h", want.sum, m_tdata[SUM_W-1:0]);
          mismatch_count++;
        end
        if (m_tuser !== want.oor) begin
          $error("out_of_range: expected %0b, actual %0b", want.oor, m_tuser);
          mismatch_count++;
        end
      end
    end
    // long hold-off on request, otherwise random stalls
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_seq) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_seq;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: too long without any transfer
  initial begin
    int quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("fenwick_tree_sum_store_top_tb: FAIL");
    $finish;
  end

  // Main sequence
  initial begin
    directed_rows = '{
      // empty tree after reset
      '{ACT_PREFIX, 11'd1024, 32'd0,          1'b1, '{48'd0, 1'b0}},
      '{ACT_POINT,  11'd1024, 32'd0,          1'b1, '{48'd0, 1'b0}},
      // index 0 queries
      '{ACT_PREFIX, 11'd0,    32'd0,          1'b1, '{48'd0, 1'b0}},
      '{ACT_POINT,  11'd0,    32'd0,          1'b1, '{48'd0, 1'b0}},
      // add at index 0 and beyond the size is refused
      '{ACT_ADD,    11'd0,    32'h7FFF_FFFF,  1'b1, '{48'd0, 1'b1}},
      '{ACT_ADD,    11'd1025, 32'd5,          1'b1, '{48'd0, 1'b1}},
      '{ACT_ADD,    11'd2047, 32'hFFFF_FFFF,  1'b1, '{48'd0, 1'b1}},
      '{ACT_PREFIX, 11'd1025, 32'd0,          1'b1, '{48'd0, 1'b1}},
      '{ACT_POINT,  11'd2047, 32'd0,          1'b1, '{48'd0, 1'b1}},
      // unused action code
      '{ACT_NOP,    11'd2047, 32'hFFFF_FFFF,  1'b1, '{48'd0, 1'b0}},
      // adds at the ends with extreme deltas
      '{ACT_ADD,    11'd1,    32'h7FFF_FFFF,  1'b1, '{48'd0, 1'b0}},
      '{ACT_ADD,    11'd1024, 32'h8000_0000,  1'b1, '{48'd0, 1'b0}},
      '{ACT_ADD,    11'd1023, 32'hFFFF_FFFF,  1'b1, '{48'd0, 1'b0}},
      '{ACT_ADD,    11'd512,  32'h1234_5678,  1'b1, '{48'd0, 1'b0}},
      '{ACT_NOP,    11'd1,    32'd5,          1'b1, '{48'd0, 1'b0}},
      '{ACT_PREFIX, 11'd1,    32'd0,          1'b1, '{48'h0000_7FFF_FFFF, 1'b0}},
      '{ACT_POINT,  11'd1024, 32'd0,          1'b1, '{48'hFFFF_8000_0000, 1'b0}},
      // mixed sums, checked against the bench tree
      '{ACT_PREFIX, 11'd1024, 32'd0,          1'b0, '{48'd0, 1'b0}},
      '{ACT_PREFIX, 11'd1023, 32'd0,          1'b0, '{48'd0, 1'b0}},
      '{ACT_POINT,  11'd1023, 32'd0,          1'b0, '{48'd0, 1'b0}},
      '{ACT_POINT,  11'd512,  32'd0,          1'b0, '{48'd0, 1'b0}},
      '{ACT_PREFIX, 11'd511,  32'd0,          1'b0, '{48'd0, 1'b0}},
      '{ACT_PREFIX, 11'd768,  32'd0,          1'b0, '{48'd0, 1'b0}}
    };
    phase_size[4] = $urandom_range(1023, 2);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table; first transfer waits out the clearing pass
    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].act, directed_rows[r].idx, directed_rows[r].delta,
                directed_rows[r].known, directed_rows[r].res);
    end

    // random phases over several sizes and idle profiles
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) write_size(SIZE_W'(phase_size[ph]));
      if (ph < 3) begin
        send_idle_pct <= 35;
        recv_idle_pct <= 86;
      end else if (ph < 6) begin
        send_idle_pct <= 86;
        recv_idle_pct <= 35;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      // receiver holds off while the sender keeps offering
      if (ph == 6) hold_seq <= hold_seq + 1;
      for (int k = 0; k < phase_items[ph]; k++) begin
        // sender pauses until the block has handed back everything
        if (ph == 4 && k == phase_items[ph] / 2) drain_results();
        send_random_item();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("fenwick_tree_sum_store_top_tb: PASS");
    else
      $display("fenwick_tree_sum_store_top_tb: FAIL");
    $finish;
  end

endmodule
